// ----- hdl/stsm_pkg.sv -----
// stsm_pkg: shared widths, types and the sine table entry function for the sine tone sweep mixer
// used by every module of the block; depends on nothing else
package stsm_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int PHASE_BITS       = 32;
	localparam int STEP_FRAC        = 16;
	localparam int STEP_BITS        = PHASE_BITS + STEP_FRAC;
	localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

	localparam int SAMPLE_W  = 16;
	localparam int RATE_W    = 18;
	localparam int FREQ_W    = 19;
	localparam int AMP_W     = 16;
	localparam int LEN_W     = 24;
	localparam int FREQ_FRAC = 4;
	localparam int AMP_ACC_W = 32;
	localparam int AMP_FRAC  = AMP_ACC_W - AMP_W;
	localparam int PROD_W    = SAMPLE_W + AMP_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEN_W;

	localparam int DIV_NUM_W = FREQ_W + STEP_BITS;
	localparam int DIV_DEN_W = RATE_W + FREQ_FRAC + LEN_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam logic [AMP_W-1:0] AMP_FULL = AMP_W'(32768);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] SHORT_FULL  = 64'd32767;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [FREQ_W-1:0] f0;
		logic [FREQ_W-1:0] f1;
		logic [AMP_W-1:0]  a0;
		logic [AMP_W-1:0]  a1;
		logic [LEN_W-1:0]  len;
	} cfg_regs_t;

	typedef struct packed {
		logic seg_init;
		logic load_step;
		logic load_ramp;
		logic load_amp;
		logic look;
		logic mul;
		logic advance;
	} tone_ctrl_t;

	// quarter-wave folded taylor series in q30, rounded to q15
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(int k);
		logic [63:0] u, r, x, x2, t, s, v;
		logic [1:0]  quad;
		u    = (64'(k) << 32) / SINE_TABLE_DEPTH;
		quad = u[31:30];
		r    = {34'd0, u[29:0]};
		if (quad[0])
			r = Q30_ONE - r;
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * SHORT_FULL + (64'd1 << 29)) >> 30;
		if (v > SHORT_FULL)
			v = SHORT_FULL;
		return quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
	endfunction

endpackage

// ----- hdl/stsm_cfg.sv -----
// stsm_cfg: configuration register file with reset values and range clean-up
// depends on stsm_pkg
module stsm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [stsm_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [stsm_pkg::CFG_DATA_W-1:0] wr_data,
	output stsm_pkg::cfg_regs_t             regs
);

	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_START_FREQ  = 3'd1;
	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_END_FREQ    = 3'd2;
	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_START_AMP   = 3'd3;
	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_END_AMP     = 3'd4;
	localparam logic [stsm_pkg::CFG_IDX_W-1:0] REG_SEG_LEN     = 3'd5;

	logic [stsm_pkg::RATE_W-1:0] rate_q;
	logic [stsm_pkg::FREQ_W-1:0] f0_q, f1_q;
	logic [stsm_pkg::AMP_W-1:0]  a0_q, a1_q;
	logic [stsm_pkg::LEN_W-1:0]  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= stsm_pkg::RATE_W'(8000);
			f0_q   <= '0;
			f1_q   <= '0;
			a0_q   <= stsm_pkg::AMP_FULL;
			a1_q   <= stsm_pkg::AMP_FULL;
			len_q  <= stsm_pkg::LEN_W'(8000);
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_SAMPLE_RATE: rate_q <= wr_data[stsm_pkg::RATE_W-1:0];
				REG_START_FREQ:  f0_q   <= wr_data[stsm_pkg::FREQ_W-1:0];
				REG_END_FREQ:    f1_q   <= wr_data[stsm_pkg::FREQ_W-1:0];
				REG_START_AMP:   a0_q   <= wr_data[stsm_pkg::AMP_W-1:0];
				REG_END_AMP:     a1_q   <= wr_data[stsm_pkg::AMP_W-1:0];
				REG_SEG_LEN:     len_q  <= wr_data[stsm_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero rate and length count as one, amplitudes clamp to full scale
	always_comb begin
		regs.rate = (rate_q == '0) ? stsm_pkg::RATE_W'(1) : rate_q;
		regs.f0   = f0_q;
		regs.f1   = f1_q;
		regs.a0   = (a0_q > stsm_pkg::AMP_FULL) ? stsm_pkg::AMP_FULL : a0_q;
		regs.a1   = (a1_q > stsm_pkg::AMP_FULL) ? stsm_pkg::AMP_FULL : a1_q;
		regs.len  = (len_q == '0) ? stsm_pkg::LEN_W'(1) : len_q;
	end

endmodule

// ----- hdl/stsm_div.sv -----
// stsm_div: shared restoring divider, one quotient bit per cycle
// depends on stsm_pkg
module stsm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [stsm_pkg::DIV_NUM_W-1:0] num,
	input  logic [stsm_pkg::DIV_DEN_W-1:0] den,
	input  logic [stsm_pkg::DIV_CNT_W-1:0] iters,
	output logic                           done,
	output logic [stsm_pkg::STEP_BITS-1:0] quo
);

	logic [stsm_pkg::DIV_NUM_W-1:0] num_q;
	logic [stsm_pkg::DIV_DEN_W-1:0] den_q;
	logic [stsm_pkg::DIV_DEN_W-1:0] rem_q;
	logic [stsm_pkg::STEP_BITS-1:0] quo_q;
	logic [stsm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [stsm_pkg::DIV_DEN_W:0]   shifted;
	logic                           fits;
	logic [stsm_pkg::DIV_DEN_W-1:0] rem_d;

	always_comb begin
		shifted = {rem_q, num_q[stsm_pkg::DIV_NUM_W-1]};
		fits    = (shifted >= {1'b0, den_q});
		rem_d   = fits ? stsm_pkg::DIV_DEN_W'(shifted - {1'b0, den_q})
		               : shifted[stsm_pkg::DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == stsm_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[stsm_pkg::DIV_NUM_W-2:0], 1'b0};
			rem_q <= rem_d;
			quo_q <= {quo_q[stsm_pkg::STEP_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hdl/stsm_tone.sv -----
// stsm_tone: phase and amplitude accumulators, sine lookup and scaling multiply
// depends on stsm_pkg
module stsm_tone (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stsm_pkg::tone_ctrl_t                 ctrl,
	input  stsm_pkg::cfg_regs_t                  cfg,
	input  logic [stsm_pkg::STEP_BITS-1:0]       quo,
	output logic signed [stsm_pkg::SAMPLE_W-1:0] mix,
	output logic                                 last
);

	logic [stsm_pkg::PHASE_BITS-1:0]        phase_acc_q;
	logic [stsm_pkg::STEP_BITS-1:0]         phase_step_q;
	logic [stsm_pkg::STEP_BITS-1:0]         phase_ramp_q;
	logic [stsm_pkg::AMP_ACC_W-1:0]         amp_acc_q;
	logic [stsm_pkg::AMP_ACC_W-1:0]         amp_ramp_q;
	logic [stsm_pkg::LEN_W-1:0]             samples_left_q;
	logic                                   tone_on_q;
	logic signed [stsm_pkg::SAMPLE_W-1:0]   sine_q;
	logic signed [stsm_pkg::PROD_W-1:0]     prod_q;

	logic                                   active;
	logic signed [stsm_pkg::PROD_W-1:0]     prod_adj;
	logic signed [stsm_pkg::PROD_W-1:0]     scaled;
	logic [stsm_pkg::SINE_IDX_W-1:0]        sine_idx;
	logic signed [stsm_pkg::SAMPLE_W-1:0]   sine_rom [stsm_pkg::SINE_TABLE_DEPTH];

	// constant sine table
	for (genvar k = 0; k < stsm_pkg::SINE_TABLE_DEPTH; k++) begin : g_rom
		assign sine_rom[k] = stsm_pkg::sine_entry(k);
	end

	assign active   = (samples_left_q != '0);
	assign sine_idx = phase_acc_q[stsm_pkg::PHASE_BITS-1 -: stsm_pkg::SINE_IDX_W];

	// shift right by 15 with the magnitude truncated toward zero
	always_comb begin
		prod_adj = prod_q[stsm_pkg::PROD_W-1] ? prod_q + stsm_pkg::PROD_W'(32767) : prod_q;
		scaled   = prod_adj >>> 15;
		mix      = (active && tone_on_q) ? scaled[stsm_pkg::SAMPLE_W-1:0] : '0;
		last     = active && (samples_left_q == stsm_pkg::LEN_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q    <= '0;
			phase_step_q   <= '0;
			phase_ramp_q   <= '0;
			amp_acc_q      <= '0;
			amp_ramp_q     <= '0;
			samples_left_q <= '0;
			tone_on_q      <= 1'b0;
		end else begin
			if (ctrl.seg_init) begin
				phase_acc_q    <= '0;
				amp_acc_q      <= {cfg.a0, {stsm_pkg::AMP_FRAC{1'b0}}};
				samples_left_q <= cfg.len;
				tone_on_q      <= (cfg.f0 != '0) || (cfg.f1 != '0);
			end
			if (ctrl.load_step)
				phase_step_q <= quo;
			if (ctrl.load_ramp)
				phase_ramp_q <= (cfg.f1 < cfg.f0) ? -quo : quo;
			if (ctrl.load_amp)
				amp_ramp_q <= (cfg.a1 < cfg.a0) ? -quo[stsm_pkg::AMP_ACC_W-1:0]
				                                : quo[stsm_pkg::AMP_ACC_W-1:0];
			if (ctrl.advance && active) begin
				samples_left_q <= samples_left_q - 1'b1;
				if (tone_on_q) begin
					phase_acc_q  <= phase_acc_q + phase_step_q[stsm_pkg::STEP_BITS-1 -:
					                                           stsm_pkg::PHASE_BITS];
					phase_step_q <= phase_step_q + phase_ramp_q;
					amp_acc_q    <= amp_acc_q + amp_ramp_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.look)
			sine_q <= sine_rom[sine_idx];
		if (ctrl.mul)
			prod_q <= sine_q * $signed({1'b0, amp_acc_q[stsm_pkg::AMP_ACC_W-1 -:
			                                            stsm_pkg::AMP_W]});
	end

endmodule

// ----- hdl/sine_tone_sweep_mixer.sv -----
// sine_tone_sweep_mixer: top level, sequencer, divider operand select and output register
// depends on stsm_pkg, stsm_cfg, stsm_div and stsm_tone
//
// use: write the six tone registers on the cfg channel (index 0..5, others ignored)
// while the block is idle, then send samples on the in channel. a beat with
// restart set loads the registers and starts a new tone segment; every sample
// of the segment gets the scaled sine added, wrapped to 16 bits, and the
// final one carries last. samples outside a segment pass through unchanged.
// each input beat gives exactly one output beat.
// timing: a plain sample steps through accept, table read, multiply and add,
// and no new sample is taken until the add step of the last one is done. a
// restart beat first runs three divisions on the shared one-bit-a-cycle
// divider before it goes on to its table read.
// in_ready is high only while the sequencer is idle. the result sits in an
// output register; a stalled receiver holds the block in its add step until
// the register frees, and no beat is lost. reset clears the tone state to
// pass-through and loads the register reset values.
module sine_tone_sweep_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [stsm_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [stsm_pkg::SAMPLE_W-1:0] out_sample,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [stsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_LOOK = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;

	localparam logic [1:0] OP_STEP = 2'd0;
	localparam logic [1:0] OP_RAMP = 2'd1;
	localparam logic [1:0] OP_AMP  = 2'd2;

	logic [2:0]                           state_q, state_d;
	logic [1:0]                           div_op_q;
	logic [1:0]                           div_sel;
	logic signed [stsm_pkg::SAMPLE_W-1:0] in_sample_q;
	logic [stsm_pkg::DIV_DEN_W-1:0]       den_len_q;
	logic                                 out_valid_q;
	logic signed [stsm_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                 last_q;

	stsm_pkg::cfg_regs_t                  cfg;
	stsm_pkg::tone_ctrl_t                 ctrl;
	logic                                 div_start;
	logic                                 div_done;
	logic [stsm_pkg::DIV_NUM_W-1:0]       div_num;
	logic [stsm_pkg::DIV_DEN_W-1:0]       div_den;
	logic [stsm_pkg::DIV_CNT_W-1:0]       div_iters;
	logic [stsm_pkg::STEP_BITS-1:0]       div_quo;
	logic [stsm_pkg::FREQ_W-1:0]          freq_diff;
	logic [stsm_pkg::AMP_W-1:0]           amp_mag;
	logic [stsm_pkg::RATE_W+stsm_pkg::FREQ_FRAC-1:0] rate_den;
	logic signed [stsm_pkg::SAMPLE_W-1:0] mix;
	logic                                 tone_last;
	logic                                 in_beat;
	logic                                 out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	stsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.regs    (cfg)
	);

	// divider operands
	always_comb begin
		rate_den  = {cfg.rate, {stsm_pkg::FREQ_FRAC{1'b0}}};
		freq_diff = (cfg.f1 >= cfg.f0) ? cfg.f1 - cfg.f0 : cfg.f0 - cfg.f1;
		amp_mag   = (cfg.a1 >= cfg.a0) ? cfg.a1 - cfg.a0 : cfg.a0 - cfg.a1;
		div_sel   = (state_q == ST_PREP) ? OP_STEP : div_op_q + 1'b1;
		unique case (div_sel)
			OP_RAMP: begin
				div_num   = {freq_diff, {stsm_pkg::STEP_BITS{1'b0}}};
				div_den   = den_len_q;
				div_iters = stsm_pkg::DIV_CNT_W'(stsm_pkg::DIV_NUM_W);
			end
			OP_AMP: begin
				div_num   = {amp_mag, {(stsm_pkg::DIV_NUM_W - stsm_pkg::AMP_W){1'b0}}};
				div_den   = stsm_pkg::DIV_DEN_W'(cfg.len);
				div_iters = stsm_pkg::DIV_CNT_W'(stsm_pkg::AMP_ACC_W);
			end
			default: begin
				div_num   = {cfg.f0, {stsm_pkg::STEP_BITS{1'b0}}};
				div_den   = stsm_pkg::DIV_DEN_W'(rate_den);
				div_iters = stsm_pkg::DIV_CNT_W'(stsm_pkg::DIV_NUM_W);
			end
		endcase
	end

	stsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		ctrl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat)
					state_d = restart ? ST_PREP : ST_LOOK;
			end
			ST_PREP: begin
				ctrl.seg_init = 1'b1;
				div_start     = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					ctrl.load_step = (div_op_q == OP_STEP);
					ctrl.load_ramp = (div_op_q == OP_RAMP);
					ctrl.load_amp  = (div_op_q == OP_AMP);
					if (div_op_q == OP_AMP)
						state_d = ST_LOOK;
					else
						div_start = 1'b1;
				end
			end
			ST_LOOK: begin
				ctrl.look = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = ST_ADD;
			end
			ST_ADD: begin
				if (out_free) begin
					ctrl.advance = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	stsm_tone u_tone (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg),
		.quo    (div_quo),
		.mix    (mix),
		.last   (tone_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_op_q    <= OP_STEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_start)
				div_op_q <= div_sel;
			if (ctrl.advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat)
			in_sample_q <= in_sample;
		if (state_q == ST_PREP)
			den_len_q <= stsm_pkg::DIV_DEN_W'(rate_den * cfg.len);
		if (ctrl.advance) begin
			out_sample_q <= in_sample_q + mix;
			last_q       <= tone_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign last       = last_q;

endmodule

// ----- tb/sv/sine_tone_sweep_mixer_tb.sv -----
`timescale 1ns / 100ps
// sine_tone_sweep_mixer_tb: self-checking bench for the sine tone sweep mixer, with a bit-exact
// tone model, a sample driver, a ready driver, a register writer and an output scoreboard
// depends on stsm_pkg and sine_tone_sweep_mixer
module sine_tone_sweep_mixer_tb;

	localparam int SW           = stsm_pkg::SAMPLE_W;
	localparam int ROM_DEPTH    = 256;
	localparam int STEP_W       = 48;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int LONG_STALL   = 300;
	localparam int ITEM_TARGET  = 1250;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] PEAK        = 64'd32767;
	localparam logic [63:0] GAIN_FULL   = 64'd32768;

	typedef enum logic [stsm_pkg::CFG_IDX_W-1:0] {
		REG_RATE,
		REG_START_FREQ,
		REG_END_FREQ,
		REG_START_AMP,
		REG_END_AMP,
		REG_SEG_LEN,
		REG_SPARE_A,
		REG_SPARE_B
	} tone_reg_e;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 restart;
	} sample_beat_t;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 last;
	} mixed_beat_t;

	logic                               clk;
	logic                               arst_n     = 1'b0;
	logic                               in_valid   = 1'b0;
	logic                               in_ready;
	logic signed [SW-1:0]               in_sample  = '0;
	logic                               restart    = 1'b0;
	logic                               out_valid;
	logic                               out_ready  = 1'b0;
	logic signed [SW-1:0]               out_sample;
	logic                               last;
	logic                               cfg_valid  = 1'b0;
	logic                               cfg_ready;
	logic [stsm_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
	logic [stsm_pkg::CFG_DATA_W-1:0]    cfg_data   = '0;

	logic in_fire_q  = 1'b0;
	logic cfg_fire_q = 1'b0;

	// tone model state
	logic signed [SW-1:0] sine_rom [ROM_DEPTH];
	logic [23:0]          tone_reg [6];
	logic [31:0]          ph_acc, gain_acc, gain_slope;
	logic [STEP_W-1:0]    ph_step, ph_slope;
	logic [23:0]          seg_left;
	logic                 tone_active;

	sample_beat_t pending [$];
	mixed_beat_t  expect_q [$];

	int n_queued, n_taken, n_out, n_starts, n_ends, n_writes, n_settings, errors;
	int stall_reqs, stall_served, in_idle_pct, out_idle_pct, in_gap, out_hold, cycles;

	sine_tone_sweep_mixer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// floor((num mod den) * 2^48 / den), bit serial
	function automatic logic [STEP_W-1:0] frac_step(logic [63:0] num, logic [63:0] den);
		logic [63:0]       rem;
		logic [STEP_W-1:0] q;
		rem = num % den;
		q   = '0;
		for (int i = 0; i < STEP_W; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= den) begin
				rem  = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic mixed_beat_t mix_sample(sample_beat_t b);
		logic [63:0] rate, f0, f1, a0, a1, seg_len, den;
		longint      gain_step, prod, part;
		int          sum;
		mixed_beat_t res;
		sum      = int'($signed(b.sample));
		res.last = 1'b0;
		if (b.restart) begin
			rate    = (tone_reg[REG_RATE] == 0) ? 64'd1 : 64'(tone_reg[REG_RATE]);
			f0      = 64'(tone_reg[REG_START_FREQ]);
			f1      = 64'(tone_reg[REG_END_FREQ]);
			a0      = (64'(tone_reg[REG_START_AMP]) > GAIN_FULL) ? GAIN_FULL
				: 64'(tone_reg[REG_START_AMP]);
			a1      = (64'(tone_reg[REG_END_AMP]) > GAIN_FULL) ? GAIN_FULL
				: 64'(tone_reg[REG_END_AMP]);
			seg_len = (tone_reg[REG_SEG_LEN] == 0) ? 64'd1 : 64'(tone_reg[REG_SEG_LEN]);
			den     = rate << 4;
			ph_acc  = '0;
			ph_step = frac_step(f0, den);
			if (f1 >= f0) begin
				ph_slope = frac_step(f1 - f0, den * seg_len);
			end else begin
				ph_slope = -frac_step(f0 - f1, den * seg_len);
			end
			gain_acc    = 32'(a0 << 16);
			gain_step   = (longint'(a1) - longint'(a0)) * 64'sd65536 / longint'(seg_len);
			gain_slope  = gain_step[31:0];
			seg_left    = seg_len[23:0];
			tone_active = (f0 != 0) || (f1 != 0);
		end
		if (seg_left != 0) begin
			if (tone_active) begin
				prod = longint'(sine_rom[ph_acc[31:24]]) * longint'({16'd0, gain_acc[31:16]});
				part = (prod >= 0) ? (prod >>> 15) : -((-prod) >>> 15);
				sum      = sum + int'(part);
				ph_acc   = ph_acc + ph_step[STEP_W-1:16];
				ph_step  = ph_step + ph_slope;
				gain_acc = gain_acc + gain_slope;
			end
			res.last = (seg_left == 1);
			seg_left = seg_left - 24'd1;
		end
		res.sample = sum[15:0];
		return res;
	endfunction

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand_field(tone_reg_e r);
		case (r)
			REG_RATE: case ($urandom_range(5))
				0: return 24'd0;
				1: return 24'd1;
				2: return 24'd192000;
				3: return 24'h03FFFF;
				default: return 24'($urandom_range(192000, 1));
			endcase
			REG_START_FREQ, REG_END_FREQ: case ($urandom_range(4))
				0: return 24'd0;
				1: return 24'h07FFFF;
				2: return 24'($urandom_range(32000));
				default: return 24'($urandom_range(24'h07FFFF));
			endcase
			REG_START_AMP, REG_END_AMP: case ($urandom_range(4))
				0: return 24'd0;
				1: return 24'd32768;
				2: return 24'($urandom_range(16'hFFFF, 32769));
				default: return 24'($urandom_range(32768));
			endcase
			default: case ($urandom_range(9))
				0: return 24'd0;
				1: return 24'hFFFFFF;
				default: return 24'($urandom_range(48, 1));
			endcase
		endcase
	endfunction

	task automatic push_item(logic signed [SW-1:0] smp, logic rs);
		pending.push_back(sample_beat_t'({smp, rs}));
		n_queued++;
	endtask

	task automatic wait_drained();
		while (n_taken != n_queued || expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(tone_reg_e idx, logic [23:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_fire_q);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setting(input logic [23:0] rate, f0, f1, a0, a1, seg);
		wait_drained();
		write_reg(REG_RATE, rate);
		write_reg(REG_START_FREQ, f0);
		write_reg(REG_END_FREQ, f1);
		write_reg(REG_START_AMP, a0);
		write_reg(REG_END_AMP, a1);
		write_reg(REG_SEG_LEN, seg);
		n_settings++;
	endtask

	// mostly whole segments with random content, some cut short, some loose noise
	task automatic queue_stream(int n, int seg_len);
		int k, body;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0, 1: begin
					repeat ($urandom_range(4, 1)) begin
						push_item(rand_sample(), $urandom_range(3) == 0);
						k++;
					end
				end
				2: begin
					body = $urandom_range((seg_len <= 64) ? seg_len - 1 : 63);
					push_item(rand_sample(), 1'b1);
					repeat (body) push_item(rand_sample(), 1'b0);
					k += body + 1;
				end
				default: begin
					if (seg_len <= 64)
						body = seg_len - 1 + $urandom_range(2);
					else
						body = $urandom_range(63);
					push_item(rand_sample(), 1'b1);
					repeat (body) push_item(rand_sample(), 1'b0);
					k += body + 1;
				end
			endcase
		end
	endtask

	always @(negedge clk) begin : sample_driver
		sample_beat_t nxt;
		if (!in_valid || in_fire_q) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				nxt = pending.pop_front();
				in_valid  <= 1'b1;
				in_sample <= nxt.sample;
				restart   <= nxt.restart;
				in_gap = pick_gap(in_idle_pct);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : ready_driver
		int gap;
		if (stall_served != stall_reqs) begin
			stall_served++;
			out_hold = LONG_STALL;
		end
		if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			gap = pick_gap(out_idle_pct);
			out_ready <= (gap == 0);
			if (gap > 0)
				out_hold = gap - 1;
		end
	end

	always @(posedge clk) begin : scoreboard
		mixed_beat_t want;
		in_fire_q  <= in_valid && in_ready;
		cfg_fire_q <= cfg_valid && cfg_ready;
		if (out_valid && out_ready) begin
			n_out++;
			if (expect_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output beat: sample %0d last %0b", out_sample, last);
			end else begin
				want = expect_q.pop_front();
				if (out_sample !== want.sample || last !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("beat %0d: expected sample %0d last %0b, got sample %0d last %0b",
							n_out, want.sample, want.last, out_sample, last);
				end
				if (want.last)
					n_ends++;
			end
		end
		if (in_valid && in_ready) begin
			expect_q.push_back(mix_sample(sample_beat_t'({in_sample, restart})));
			n_taken++;
			if (restart)
				n_starts++;
		end
		if (cfg_valid && cfg_ready) begin
			n_writes++;
			case (tone_reg_e'(cfg_index))
				REG_RATE: tone_reg[REG_RATE] = cfg_data & 24'h03FFFF;
				REG_START_FREQ, REG_END_FREQ: tone_reg[cfg_index] = cfg_data & 24'h07FFFF;
				REG_START_AMP, REG_END_AMP: tone_reg[cfg_index] = cfg_data & 24'h00FFFF;
				REG_SEG_LEN: tone_reg[REG_SEG_LEN] = cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("sine_tone_sweep_mixer: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [63:0] u, r, x, x2, t, s, v;
		logic [1:0]  quad;
		int          len, n_phase;
		// quarter-wave folded taylor sine in q30, rounded to q15
		for (int k = 0; k < ROM_DEPTH; k++) begin
			u    = (64'(k) << 32) / ROM_DEPTH;
			quad = u[31:30];
			r    = {34'd0, u[29:0]};
			if (quad[0])
				r = ONE_Q30 - r;
			x  = (r * PI_HALF_Q30) >> 30;
			x2 = (x * x) >> 30;
			t  = ONE_Q30 - x2 / 64'd72;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			v  = (s * PEAK + (64'd1 << 29)) >> 30;
			if (v > PEAK)
				v = PEAK;
			sine_rom[k] = quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
		end
		tone_reg = '{24'd8000, 24'd0, 24'd0, 24'd32768, 24'd32768, 24'd8000};
		ph_acc      = '0;
		ph_step     = '0;
		ph_slope    = '0;
		gain_acc    = '0;
		gain_slope  = '0;
		seg_left    = '0;
		tone_active = 1'b0;
		in_idle_pct  = 30;
		out_idle_pct = 30;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// pass-through after reset, then a silent segment from the reset values
		push_item(16'sh7FFF, 1'b0);
		push_item(16'sh8000, 1'b0);
		push_item(16'sh0000, 1'b0);
		push_item(16'shFFFF, 1'b0);
		push_item(16'sh5555, 1'b0);
		push_item(16'shAAAA, 1'b0);
		push_item(16'sh04D2, 1'b1);
		push_item(16'shFFFB, 1'b0);
		push_item(16'sh004D, 1'b0);

		// steady full-scale tone, a wrap at the top rail, then pass-through after the segment
		load_setting(24'd8000, 24'd7040, 24'd7040, 24'd32768, 24'd32768, 24'd6);
		push_item(16'sh0000, 1'b1);
		push_item(16'sh7FFF, 1'b0);
		push_item(16'sh7FFF, 1'b0);
		push_item(16'sh8000, 1'b0);
		push_item(16'sh8000, 1'b0);
		push_item(16'sh0064, 1'b0);
		push_item(16'sh0005, 1'b0);

		// zero rate and length, clamped amplitude, downward sweep, unused indexes
		load_setting(24'd0, 24'h07FFFF, 24'd0, 24'h00FFFF, 24'd0, 24'd0);
		write_reg(REG_SPARE_A, 24'hFFFFFF);
		write_reg(REG_SPARE_B, 24'h123456);
		push_item(16'sh7FFF, 1'b1);
		push_item(16'sh8000, 1'b1);
		push_item(16'sh0000, 1'b0);

		// top rate, upward sweep with rising amplitude, restart mid segment
		load_setting(24'h03FFFF, 24'd0, 24'h07FFFF, 24'd0, 24'd32768, 24'd5);
		push_item(16'shFFFF, 1'b1);
		push_item(16'sh0002, 1'b0);
		push_item(16'sh0003, 1'b0);
		push_item(16'sh0004, 1'b1);
		push_item(16'sh8000, 1'b0);
		push_item(16'sh7FFF, 1'b0);

		n_phase = 0;
		while (n_queued < ITEM_TARGET) begin
			len = rand_field(REG_SEG_LEN);
			load_setting(rand_field(REG_RATE), rand_field(REG_START_FREQ),
				rand_field(REG_END_FREQ), rand_field(REG_START_AMP),
				rand_field(REG_END_AMP), len);
			if ($urandom_range(3) == 0)
				write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
					24'($urandom));
			in_idle_pct  = (n_phase == 0) ? 0 : $urandom_range(2) * 25;
			out_idle_pct = (n_phase == 0) ? 0 : $urandom_range(2) * 25;
			// receiver holds off while samples keep coming
			if (n_phase == 2 || n_phase == 5)
				stall_reqs++;
			queue_stream($urandom_range(160, 80), (len == 0) ? 1 : len);
			n_phase++;
		end

		wait_drained();
		repeat (20) @(negedge clk);
		$display("covered %0d samples over %0d register settings: %0d segment starts, %0d ends",
			n_taken, n_settings, n_starts, n_ends);
		$display("%0d register writes, %0d output beats checked, %0d errors",
			n_writes, n_out, errors);
		if (errors == 0 && expect_q.size() == 0)
			$display("sine_tone_sweep_mixer: match");
		else
			$display("sine_tone_sweep_mixer: mismatch");
		$finish;
	end

endmodule
